@@ rtl/iae_pkg.sv @@
// Package for the IMA ADPCM encoder: item type, index limits, register
// indexes and the step and index adjustment tables. No dependencies.
`default_nettype none
package iae_pkg;

  localparam int unsigned FifoDepthDefault = 2;
  localparam logic [6:0] MaxIndex = 7'd88;

  localparam logic RegStartPredictor = 1'b0;
  localparam logic RegStartIndex     = 1'b1;

  typedef struct packed {
    logic [15:0] sample;
    logic        start;
    logic        last;
    logic [15:0] start_pred;
    logic [6:0]  start_idx;
  } iae_item_t;

  function automatic logic [14:0] iae_step(input logic [6:0] idx);
    logic [14:0] s;
    case (idx)
      7'd0: s = 15'd7;      7'd1: s = 15'd8;      7'd2: s = 15'd9;
      7'd3: s = 15'd10;     7'd4: s = 15'd11;     7'd5: s = 15'd12;
      7'd6: s = 15'd13;     7'd7: s = 15'd14;     7'd8: s = 15'd16;
      7'd9: s = 15'd17;     7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  function automatic logic signed [7:0] iae_adjust(input logic [2:0] mag);
    logic signed [7:0] a;
    case (mag)
      3'd4: a = 8'sd2;
      3'd5: a = 8'sd4;
      3'd6: a = 8'sd6;
      3'd7: a = 8'sd8;
      default: a = -8'sd1;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ rtl/iae_front.sv @@
// Front end of the IMA ADPCM encoder: holds the block start registers and
// builds a queue item for each accepted sample. Depends on iae_pkg.
`default_nettype none
module iae_front import iae_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] sample_i,
  input  wire logic        block_start_i,
  input  wire logic        block_last_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output iae_item_t        q_item_o
);

  logic [15:0] start_pred_q, start_pred_d;
  logic [6:0]  start_idx_q, start_idx_d;
  logic [6:0]  start_idx_clamped;

  always_comb begin
    start_pred_d = start_pred_q;
    start_idx_d  = start_idx_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == RegStartPredictor) begin
        start_pred_d = cfg_data_i;
      end else begin
        start_idx_d = cfg_data_i[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pred_q <= '0;
      start_idx_q  <= '0;
    end else begin
      start_pred_q <= start_pred_d;
      start_idx_q  <= start_idx_d;
    end
  end

  assign start_idx_clamped = (start_idx_q > MaxIndex) ? MaxIndex : start_idx_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign q_push_o    = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.sample     = sample_i;
    q_item_o.start      = block_start_i;
    q_item_o.last       = block_last_i;
    q_item_o.start_pred = start_pred_q;
    q_item_o.start_idx  = start_idx_clamped;
  end

endmodule
`default_nettype wire

@@ rtl/iae_fifo.sv @@
// Short item queue between front and back of the IMA ADPCM encoder.
// Depends on iae_pkg for the item type.
`default_nettype none
module iae_fifo import iae_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire iae_item_t item_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output iae_item_t      item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  iae_item_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("Queue count exceeds depth.");
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!valid_o && !push_i) |=> !valid_o)
    else $error("Queue became non-empty without a push.");
`endif

endmodule
`default_nettype wire

@@ rtl/iae_back.sv @@
// Back end of the IMA ADPCM encoder: quantizer, predictor, step index,
// nibble packing and the output register. Depends on iae_pkg.
`default_nettype none
module iae_back import iae_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire iae_item_t   q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       code_byte_o,
  output logic             block_end_o,
  output logic [15:0]      predictor_now_o,
  output logic [6:0]       index_now_o
);

  logic [15:0] pred_q, pred_d;
  logic [6:0]  idx_q, idx_d;
  logic        pending_q, pending_d;
  logic [3:0]  held_q, held_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        end_q, end_d;
  logic [15:0] pnow_q;
  logic [6:0]  inow_q;

  logic        can_take;
  logic [15:0] pred_base;
  logic [6:0]  idx_base;
  logic        phase_base;
  logic [16:0] s0, s1, s2, r0, r1, r2, move;
  logic signed [16:0] diff;
  logic        neg, b2, b1, b0;
  logic signed [17:0] pred_sum;
  logic [15:0] pred_new;
  logic signed [7:0] idx_sum;
  logic [6:0]  idx_new;
  logic [3:0]  code;
  logic        emit;

  assign can_take = !out_valid_q || out_ready_i;
  assign q_pop_o  = q_valid_i && can_take;

  assign pred_base  = q_item_i.start ? q_item_i.start_pred : pred_q;
  assign idx_base   = q_item_i.start ? q_item_i.start_idx : idx_q;
  assign phase_base = q_item_i.start ? 1'b0 : pending_q;

  always_comb begin
    s0   = {2'b00, iae_step(idx_base)};
    s1   = s0 >> 1;
    s2   = s0 >> 2;
    diff = $signed({q_item_i.sample[15], q_item_i.sample})
         - $signed({pred_base[15], pred_base});
    neg  = diff[16];
    r0   = neg ? 17'(-diff) : 17'(diff);
    b2   = (r0 >= s0);
    r1   = b2 ? r0 - s0 : r0;
    b1   = (r1 >= s1);
    r2   = b1 ? r1 - s1 : r1;
    b0   = (r2 >= s2);
    move = (s0 >> 3) + (b2 ? s0 : 17'd0) + (b1 ? s1 : 17'd0) + (b0 ? s2 : 17'd0);
    if (neg) begin
      pred_sum = $signed({{2{pred_base[15]}}, pred_base}) - $signed({1'b0, move});
    end else begin
      pred_sum = $signed({{2{pred_base[15]}}, pred_base}) + $signed({1'b0, move});
    end
    if (pred_sum > 18'sd32767) begin
      pred_new = 16'h7fff;
    end else if (pred_sum < -18'sd32768) begin
      pred_new = 16'h8000;
    end else begin
      pred_new = pred_sum[15:0];
    end
    code    = {neg, b2, b1, b0};
    idx_sum = $signed({1'b0, idx_base}) + iae_adjust(code[2:0]);
    if (idx_sum < 8'sd0) begin
      idx_new = '0;
    end else if (idx_sum > $signed({1'b0, MaxIndex})) begin
      idx_new = MaxIndex;
    end else begin
      idx_new = idx_sum[6:0];
    end
  end

  always_comb begin
    pred_d      = pred_q;
    idx_d       = idx_q;
    pending_d   = pending_q;
    held_d      = held_q;
    out_valid_d = out_valid_q && !out_ready_i;
    byte_d      = byte_q;
    end_d       = end_q;
    emit        = 1'b0;
    if (q_pop_o) begin
      pred_d = pred_new;
      idx_d  = idx_new;
      if (!phase_base) begin
        if (q_item_i.last) begin
          emit      = 1'b1;
          byte_d    = {code, 4'b0000};
          pending_d = 1'b0;
          held_d    = '0;
        end else begin
          held_d    = code;
          pending_d = 1'b1;
        end
      end else begin
        emit      = 1'b1;
        byte_d    = {held_q, code};
        pending_d = 1'b0;
        held_d    = '0;
      end
      end_d = q_item_i.last;
      if (emit) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q      <= '0;
      idx_q       <= '0;
      pending_q   <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pred_q      <= pred_d;
      idx_q       <= idx_d;
      pending_q   <= pending_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && emit) begin
      byte_q <= byte_d;
      end_q  <= end_d;
      pnow_q <= pred_new;
      inow_q <= idx_new;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign code_byte_o     = byte_q;
  assign block_end_o     = end_q;
  assign predictor_now_o = pnow_q;
  assign index_now_o     = inow_q;

`ifndef SYNTHESIS
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= MaxIndex)
    else $error("Step index left the table range.");
  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !q_pop_o)
    else $error("Item taken while a result is stalled.");
  a_last_clears_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_item_i.last) |=> (!pending_q && out_valid_q))
    else $error("Last item of a block did not flush its byte.");
`endif

endmodule
`default_nettype wire

@@ rtl/ima_adpcm_encoder.sv @@
// IMA/DVI 4-bit ADPCM encoder top level: front end, item queue and back end.
// Depends on iae_pkg, iae_front, iae_fifo and iae_back.
//
// The encoder takes one signed 16-bit sample per clock cycle while the output
// is not stalled, a rate set by the combinational quantizer and predictor
// update in the back end, and packs two 4-bit codes per output byte, the first
// code in the high nibble. A sample is registered in the queue before it
// reaches the back end, and a completed byte is held in the output register.
// The queue holds FifoDepth items, so input keeps flowing while the output is
// stalled until the queue is full. Block start values are written
// on the configuration port, index 0 for the start predictor and index 1 for
// the start index, and should be written only while no item is in flight.
`default_nettype none
module ima_adpcm_encoder import iae_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] sample_i,
  input  wire logic        block_start_i,
  input  wire logic        block_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       code_byte_o,
  output logic             block_end_o,
  output logic [15:0]      predictor_now_o,
  output logic [6:0]       index_now_o
);

  iae_item_t push_item, head_item;
  logic      q_full, q_push, q_valid, q_pop;

  iae_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .block_start_i (block_start_i),
    .block_last_i  (block_last_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (push_item)
  );

  iae_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  iae_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (head_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .code_byte_o     (code_byte_o),
    .block_end_o     (block_end_o),
    .predictor_now_o (predictor_now_o),
    .index_now_o     (index_now_o)
  );

endmodule
`default_nettype wire
